@@ hdl/hpr_pkg.sv @@
// Shared types, constants and helpers for the homography pixel remap block.
// No dependencies; every other file of the block uses this package.
package hpr_pkg;

  localparam int unsigned FrameWidthDef  = 1920;
  localparam int unsigned FrameHeightDef = 1080;

  localparam int unsigned ColW  = 12;
  localparam int unsigned PixW  = 32;
  localparam int unsigned DestW = 16;
  localparam int unsigned GainW = 32;
  localparam int unsigned PerspW = 48;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 48;

  // Product and sum widths: numerators in Q.24, denominator in Q.40
  localparam int unsigned ProdNW = GainW + ColW + 1;   // 45
  localparam int unsigned ProdWW = PerspW + ColW + 1;  // 61
  localparam int unsigned NumW   = 47;
  localparam int unsigned DenW   = 62;
  localparam int unsigned RemW   = DenW + 1;
  localparam int unsigned QuoW   = 16;

  localparam logic [DenW-1:0] WOne   = DenW'(64'h100_0000_0000);
  localparam logic [DenW-1:0] WEps   = DenW'(131072);

  localparam logic [GainW-1:0] GainOne = 32'h0100_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_XX   = 4'd0,
    REG_GAIN_XY   = 4'd1,
    REG_OFFSET_X  = 4'd2,
    REG_GAIN_YX   = 4'd3,
    REG_GAIN_YY   = 4'd4,
    REG_OFFSET_Y  = 4'd5,
    REG_PERSP_COL = 4'd6,
    REG_PERSP_ROW = 4'd7
  } reg_idx_e;

  // One item in flight through the divider stages
  typedef struct packed {
    logic [RemW-1:0] rem_x;
    logic [RemW-1:0] rem_y;
    logic [QuoW-1:0] quo_x;
    logic [QuoW-1:0] quo_y;
    logic [DenW-1:0] abs_w;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
    logic            degen;
    logic [PixW-1:0] pix;
  } div_t;

  // One restoring step: shift the remainder, subtract the divisor if it fits
  function automatic logic [RemW+QuoW-1:0] div_step(logic [RemW-1:0] rem,
                                                    logic [QuoW-1:0] quo,
                                                    logic [DenW-1:0] den);
    logic [RemW-1:0] sh;
    logic [RemW-1:0] dz;
    logic            fit;
    sh  = {rem[RemW-2:0], 1'b0};
    dz  = {1'b0, den};
    fit = (sh >= dz);
    return {fit ? sh - dz : sh, quo[QuoW-2:0], fit};
  endfunction

  // Round half away from zero, apply sign, saturate to 16 bits
  function automatic logic [DestW-1:0] finish(logic [RemW-1:0] rem,
                                              logic [QuoW-1:0] quo,
                                              logic [DenW-1:0] den,
                                              logic neg, logic ovf);
    logic [RemW-1:0] twice;
    logic [QuoW:0]   q;
    twice = {rem[RemW-2:0], 1'b0};
    q = {1'b0, quo} + {{QuoW{1'b0}}, (twice >= {1'b0, den})};
    if (neg) begin
      if (ovf || q > 17'd32768) return 16'h8000;
      return DestW'(~q + 17'd1);
    end
    if (ovf || q > 17'd32767) return 16'h7fff;
    return q[DestW-1:0];
  endfunction

endpackage

@@ hdl/hpr_if.sv @@
// Handshake channel interfaces for the homography pixel remap block.
// Depends on hpr_pkg for field widths.
interface hpr_src_if;
  logic                          valid;
  logic                          ready;
  logic [hpr_pkg::ColW-1:0]      src_col;
  logic [hpr_pkg::ColW-1:0]      src_row;
  logic [hpr_pkg::PixW-1:0]      pixel;
  modport source (output valid, src_col, src_row, pixel, input ready);
  modport sink   (input valid, src_col, src_row, pixel, output ready);
endinterface

interface hpr_dst_if;
  logic                                valid;
  logic                                ready;
  logic signed [hpr_pkg::DestW-1:0]    dest_col;
  logic signed [hpr_pkg::DestW-1:0]    dest_row;
  logic        [hpr_pkg::PixW-1:0]     pixel_out;
  logic                                in_frame;
  modport source (output valid, dest_col, dest_row, pixel_out, in_frame, input ready);
  modport sink   (input valid, dest_col, dest_row, pixel_out, in_frame, output ready);
endinterface

interface hpr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hpr_pkg::CfgIdxW-1:0]      index;
  logic [hpr_pkg::CfgDataW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/homography_pixel_remap.sv @@
// Pipeline from accept to result: multiply, sum, setup, 16 divider steps, round.
// Throughput: one item per cycle while the output is not held; the 16-stage restoring divider is fully pipelined.
// A stall at the output holds every stage; ready drops only while the output is held.
// Reset clears all valid bits and loads the identity transform into the coefficients.
// Top level; depends on hpr_pkg and the channel interfaces in hpr_if.sv.
module homography_pixel_remap #(
  parameter int unsigned FRAME_WIDTH  = hpr_pkg::FrameWidthDef,
  parameter int unsigned FRAME_HEIGHT = hpr_pkg::FrameHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hpr_src_if.sink     src_i,
  hpr_dst_if.source   dst_o,
  hpr_cfg_if.sink     cfg_i
);

  localparam int unsigned NSteps = hpr_pkg::QuoW;

  // coefficients
  logic signed [hpr_pkg::GainW-1:0]  a_q, b_q, c_q, d_q, e_q, f_q;
  logic signed [hpr_pkg::PerspW-1:0] g_q, h_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= hpr_pkg::GainOne;
      b_q <= '0;
      c_q <= '0;
      d_q <= '0;
      e_q <= hpr_pkg::GainOne;
      f_q <= '0;
      g_q <= '0;
      h_q <= '0;
    end else if (cfg_i.valid) begin
      case (hpr_pkg::reg_idx_e'(cfg_i.index))
        hpr_pkg::REG_GAIN_XX:   a_q <= cfg_i.data[hpr_pkg::GainW-1:0];
        hpr_pkg::REG_GAIN_XY:   b_q <= cfg_i.data[hpr_pkg::GainW-1:0];
        hpr_pkg::REG_OFFSET_X:  c_q <= cfg_i.data[hpr_pkg::GainW-1:0];
        hpr_pkg::REG_GAIN_YX:   d_q <= cfg_i.data[hpr_pkg::GainW-1:0];
        hpr_pkg::REG_GAIN_YY:   e_q <= cfg_i.data[hpr_pkg::GainW-1:0];
        hpr_pkg::REG_OFFSET_Y:  f_q <= cfg_i.data[hpr_pkg::GainW-1:0];
        hpr_pkg::REG_PERSP_COL: g_q <= cfg_i.data;
        hpr_pkg::REG_PERSP_ROW: h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless the output is held
  logic adv;
  logic out_vld_q;
  assign adv         = !out_vld_q || dst_o.ready;
  assign src_i.ready = adv;

  // stage 1: products
  logic signed [hpr_pkg::ColW:0] col_s, row_s;
  assign col_s = $signed({1'b0, src_i.src_col});
  assign row_s = $signed({1'b0, src_i.src_row});

  logic                               s1_vld_q;
  logic signed [hpr_pkg::ProdNW-1:0]  pa_q, pb_q, pd_q, pe_q;
  logic signed [hpr_pkg::ProdWW-1:0]  pg_q, ph_q;
  logic signed [hpr_pkg::GainW-1:0]   c1_q, f1_q;
  logic        [hpr_pkg::PixW-1:0]    pix1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q   <= a_q * col_s;
      pb_q   <= b_q * row_s;
      pd_q   <= d_q * col_s;
      pe_q   <= e_q * row_s;
      pg_q   <= g_q * col_s;
      ph_q   <= h_q * row_s;
      c1_q   <= c_q;
      f1_q   <= f_q;
      pix1_q <= src_i.pixel;
    end
  end

  // stage 2: sums
  logic                              s2_vld_q;
  logic signed [hpr_pkg::NumW-1:0]   nx_q, ny_q;
  logic signed [hpr_pkg::DenW-1:0]   w_q;
  logic        [hpr_pkg::PixW-1:0]   pix2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q <= hpr_pkg::NumW'(pa_q) + hpr_pkg::NumW'(pb_q)
              + (hpr_pkg::NumW'(c1_q) <<< 8);
      ny_q <= hpr_pkg::NumW'(pd_q) + hpr_pkg::NumW'(pe_q)
              + (hpr_pkg::NumW'(f1_q) <<< 8);
      w_q  <= hpr_pkg::DenW'(pg_q) + hpr_pkg::DenW'(ph_q) + $signed(hpr_pkg::WOne);
      pix2_q <= pix1_q;
    end
  end

  // stage 3: magnitudes, signs, overflow and degenerate checks
  logic [hpr_pkg::DenW-1:0] aw;
  logic [hpr_pkg::NumW-1:0] anx, any;
  assign aw  = w_q[hpr_pkg::DenW-1] ? hpr_pkg::DenW'(-w_q) : w_q;
  assign anx = nx_q[hpr_pkg::NumW-1] ? hpr_pkg::NumW'(-nx_q) : nx_q;
  assign any = ny_q[hpr_pkg::NumW-1] ? hpr_pkg::NumW'(-ny_q) : ny_q;

  hpr_pkg::div_t dv_q [NSteps+1];
  logic [NSteps:0] dv_vld_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].rem_x <= hpr_pkg::RemW'(anx);
      dv_q[0].rem_y <= hpr_pkg::RemW'(any);
      dv_q[0].quo_x <= '0;
      dv_q[0].quo_y <= '0;
      dv_q[0].abs_w <= aw;
      dv_q[0].neg_x <= nx_q[hpr_pkg::NumW-1] ^ w_q[hpr_pkg::DenW-1];
      dv_q[0].neg_y <= ny_q[hpr_pkg::NumW-1] ^ w_q[hpr_pkg::DenW-1];
      // |n| >= |w| means the quotient is at least 65536
      dv_q[0].ovf_x <= hpr_pkg::DenW'(anx) >= aw;
      dv_q[0].ovf_y <= hpr_pkg::DenW'(any) >= aw;
      dv_q[0].degen <= aw <= hpr_pkg::WEps;
      dv_q[0].pix   <= pix2_q;
      for (int k = 1; k <= NSteps; k++) begin
        dv_q[k].abs_w <= dv_q[k-1].abs_w;
        dv_q[k].neg_x <= dv_q[k-1].neg_x;
        dv_q[k].neg_y <= dv_q[k-1].neg_y;
        dv_q[k].ovf_x <= dv_q[k-1].ovf_x;
        dv_q[k].ovf_y <= dv_q[k-1].ovf_y;
        dv_q[k].degen <= dv_q[k-1].degen;
        dv_q[k].pix   <= dv_q[k-1].pix;
        {dv_q[k].rem_x, dv_q[k].quo_x} <=
          hpr_pkg::div_step(dv_q[k-1].rem_x, dv_q[k-1].quo_x, dv_q[k-1].abs_w);
        {dv_q[k].rem_y, dv_q[k].quo_y} <=
          hpr_pkg::div_step(dv_q[k-1].rem_y, dv_q[k-1].quo_y, dv_q[k-1].abs_w);
      end
    end
  end

  // final stage: rounding, saturation, zero result when degenerate, frame check
  hpr_pkg::div_t        last;
  logic [hpr_pkg::DestW-1:0] dx_d, dy_d;
  logic                 fr_d;
  assign last = dv_q[NSteps];
  always_comb begin
    dx_d = '0;
    dy_d = '0;
    if (!last.degen) begin
      dx_d = hpr_pkg::finish(last.rem_x, last.quo_x, last.abs_w, last.neg_x, last.ovf_x);
      dy_d = hpr_pkg::finish(last.rem_y, last.quo_y, last.abs_w, last.neg_y, last.ovf_y);
    end
    fr_d = !dx_d[hpr_pkg::DestW-1] && (dx_d < hpr_pkg::DestW'(FRAME_WIDTH))
        && !dy_d[hpr_pkg::DestW-1] && (dy_d < hpr_pkg::DestW'(FRAME_HEIGHT));
  end

  logic [hpr_pkg::DestW-1:0] dx_q, dy_q;
  logic [hpr_pkg::PixW-1:0]  pixo_q;
  logic                      fr_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      fr_q   <= fr_d;
      pixo_q <= last.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= src_i.valid;
      s2_vld_q  <= s1_vld_q;
      dv_vld_q  <= {dv_vld_q[NSteps-1:0], s2_vld_q};
      out_vld_q <= dv_vld_q[NSteps];
    end
  end

  assign dst_o.valid     = out_vld_q;
  assign dst_o.dest_col  = dx_q;
  assign dst_o.dest_row  = dy_q;
  assign dst_o.pixel_out = pixo_q;
  assign dst_o.in_frame  = fr_q;

endmodule

@@ hdl/hpr_checker.sv @@
// Port-level assertions for homography_pixel_remap, attached by bind.
// Depends on hpr_pkg and the top level's channel interfaces.
module hpr_checker #(
  parameter int unsigned FRAME_WIDTH  = hpr_pkg::FrameWidthDef,
  parameter int unsigned FRAME_HEIGHT = hpr_pkg::FrameHeightDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [hpr_pkg::DestW-1:0]   out_col_i,
  input logic [hpr_pkg::DestW-1:0]   out_row_i,
  input logic                        out_frame_i,
  input logic                        cfg_ready_i
);

  // output only stalls the input when a result is actually held
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && !out_ready_i) |-> in_ready_i)
    else $error("input blocked without a held result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_col_i) && $stable(out_row_i))
    else $error("held result changed");

  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_frame_i == (!out_col_i[hpr_pkg::DestW-1]
      && out_col_i < hpr_pkg::DestW'(FRAME_WIDTH) && !out_row_i[hpr_pkg::DestW-1]
      && out_row_i < hpr_pkg::DestW'(FRAME_HEIGHT)))
    else $error("in_frame disagrees with destination");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("config port not ready");

endmodule

bind homography_pixel_remap hpr_checker #(
  .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)
) u_hpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (src_i.ready),
  .out_valid_i (dst_o.valid),
  .out_ready_i (dst_o.ready),
  .out_col_i   (dst_o.dest_col),
  .out_row_i   (dst_o.dest_row),
  .out_frame_i (dst_o.in_frame),
  .cfg_ready_i (cfg_i.ready)
);
